/* sv/u8dec_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 decoder package
// Byte classes, field widths and the lead byte classifier.
// ----------------------------------------------------------------------------
package u8dec_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CpW    = 21;
  localparam int unsigned CntW   = 3;
  localparam int unsigned MTdataW = 24;

  typedef enum logic [2:0] {
    CLS_CONT  = 3'd0,
    CLS_ASCII = 3'd1,
    CLS_LEAD2 = 3'd2,
    CLS_LEAD3 = 3'd3,
    CLS_LEAD4 = 3'd4,
    CLS_BAD   = 3'd5
  } byte_class_e;

  // Classifies a byte by its top five bits.
  function automatic byte_class_e lead_class(input logic [4:0] top);
    byte_class_e cls;
    case (top) inside
      [5'd0 : 5'd15]:  cls = CLS_ASCII;
      [5'd16 : 5'd23]: cls = CLS_CONT;
      [5'd24 : 5'd27]: cls = CLS_LEAD2;
      [5'd28 : 5'd29]: cls = CLS_LEAD3;
      5'd30:           cls = CLS_LEAD4;
      default:         cls = CLS_BAD;
    endcase
    return cls;
  endfunction

endpackage

/* sv/utf8_byte_stream_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UTF-8 byte stream decoder
// Gathers UTF-8 sequences one byte per transaction and emits code points,
// with one error transaction per byte of a broken or truncated sequence.
// ----------------------------------------------------------------------------
// The first result of a byte appears in the cycle after the byte is accepted.
// Throughput: one byte per cycle while each byte yields at most one result
// and the output is not stalled; a byte that yields several results holds
// the input until they are replayed, one result per cycle while m_axis_tready is high.
// Reset: rst_ni clears the open sequence and empties the output register.
module utf8_byte_stream_decoder (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [u8dec_pkg::ByteW-1:0]     s_axis_tdata,  // [7:0] data_byte
  input  logic                            s_axis_tlast,  // end_of_string
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [20:0] code_point, [23:21] byte_count
  output logic [u8dec_pkg::MTdataW-1:0]   m_axis_tdata,
  output logic                            m_axis_tuser,  // [0] bad_sequence
  output logic                            m_axis_tlast   // run_last
);
  import u8dec_pkg::*;

  logic [CpW-1:0]  pv_q, pv_d;
  logic [CntW-1:0] len_q, len_d;
  logic [CntW-1:0] gath_q, gath_d;

  logic [CntW-1:0] err_left_q, err_left_d;
  logic            tail_v_q, tail_v_d;
  logic [CpW-1:0]  tail_cp_q, tail_cp_d;
  logic            tail_bad_q, tail_bad_d;
  logic [CntW-1:0] tail_cnt_q, tail_cnt_d;

  byte_class_e     cls;
  logic [CpW-1:0]  pv_shift;
  logic [CntW-1:0] gath_inc;
  logic            fresh;
  logic            s_fire, m_fire, busy;

  assign busy          = (err_left_q != '0) || tail_v_q;
  assign m_axis_tvalid = busy;
  assign m_fire        = m_axis_tvalid && m_axis_tready;
  assign m_axis_tlast  = (err_left_q == '0) ||
                         ((err_left_q == CntW'(1)) && !tail_v_q);
  assign s_axis_tready = !busy || (m_fire && m_axis_tlast);
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    if (err_left_q != '0) begin
      m_axis_tdata = {CntW'(1), CpW'(0)};
      m_axis_tuser = 1'b1;
    end else begin
      m_axis_tdata = {tail_cnt_q, tail_cp_q};
      m_axis_tuser = tail_bad_q;
    end
  end

  always_comb begin
    cls        = lead_class(s_axis_tdata[7:3]);
    pv_shift   = {pv_q[CpW-7:0], s_axis_tdata[5:0]};
    gath_inc   = gath_q + CntW'(1);
    pv_d       = pv_q;
    len_d      = len_q;
    gath_d     = gath_q;
    err_left_d = '0;
    tail_v_d   = 1'b0;
    tail_cp_d  = '0;
    tail_bad_d = 1'b0;
    tail_cnt_d = CntW'(1);
    fresh      = 1'b0;

    if (len_q == '0) begin
      fresh = 1'b1;
    end else if (cls == CLS_CONT) begin
      if (gath_inc >= len_q) begin
        tail_v_d   = 1'b1;
        tail_cp_d  = pv_shift;
        tail_cnt_d = len_q;
        pv_d       = '0;
        len_d      = '0;
        gath_d     = '0;
      end else if (s_axis_tlast) begin
        err_left_d = gath_inc;
        pv_d       = '0;
        len_d      = '0;
        gath_d     = '0;
      end else begin
        pv_d   = pv_shift;
        gath_d = gath_inc;
      end
    end else begin
      err_left_d = gath_q;
      pv_d       = '0;
      len_d      = '0;
      gath_d     = '0;
      fresh      = 1'b1;
    end

    if (fresh) begin
      case (cls)
        CLS_ASCII: begin
          tail_v_d  = 1'b1;
          tail_cp_d = CpW'(s_axis_tdata);
        end
        CLS_LEAD2, CLS_LEAD3, CLS_LEAD4: begin
          if (s_axis_tlast) begin
            tail_v_d   = 1'b1;
            tail_bad_d = 1'b1;
          end else begin
            len_d  = CntW'(cls);
            gath_d = CntW'(1);
            if (cls == CLS_LEAD2) begin
              pv_d = CpW'(s_axis_tdata[4:0]);
            end else if (cls == CLS_LEAD3) begin
              pv_d = CpW'(s_axis_tdata[3:0]);
            end else begin
              pv_d = CpW'(s_axis_tdata[2:0]);
            end
          end
        end
        default: begin
          tail_v_d   = 1'b1;
          tail_bad_d = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q       <= '0;
      len_q      <= '0;
      gath_q     <= '0;
      err_left_q <= '0;
      tail_v_q   <= 1'b0;
    end else if (s_fire) begin
      pv_q       <= pv_d;
      len_q      <= len_d;
      gath_q     <= gath_d;
      err_left_q <= err_left_d;
      tail_v_q   <= tail_v_d;
    end else if (m_fire) begin
      if (err_left_q != '0) begin
        err_left_q <= err_left_q - CntW'(1);
      end else begin
        tail_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      tail_cp_q  <= tail_cp_d;
      tail_bad_q <= tail_bad_d;
      tail_cnt_q <= tail_cnt_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      (m_axis_tdata[CpW-1:0] == '0) && (m_axis_tdata[CpW+CntW-1:CpW] == CntW'(1)))
    else $error("Error result carries a code point or a byte count other than one.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |-> !busy || (m_fire && m_axis_tlast))
    else $error("Byte accepted while earlier results are still pending.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q != '0 |-> (gath_q != '0) && (gath_q < len_q) && (len_q <= CntW'(4)))
    else $error("Open sequence has an inconsistent byte count.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && s_axis_tlast |=> len_q == '0)
    else $error("Sequence left open after the last byte of a string.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_left_q > CntW'(3) |-> 1'b0)
    else $error("Error run longer than the longest broken sequence.");

endmodule
